>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset.
`define ASSERT_SYNC(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle requires a consequence in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_SYNC(lbl, prop, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> hw/rtl/pcfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcfc_pkg
// Types, constants and the byte-wide CRC-16 update for the frame checker.
// ----------------------------------------------------------------------------
package pcfc_pkg;

  localparam logic [7:0]  MAX_PAYLOAD_BYTES = 8'd255;
  localparam logic [15:0] CRC_POLY          = 16'h1021;
  localparam logic [15:0] CRC_INIT          = 16'h0000;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
    logic [7:0] payload_length;
    logic       crc_present;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_verdict;
    logic       end_of_frame;
    logic       crc_ok;
    logic       length_error;
  } out_word_t;

  // MSB-first CRC-16 over one byte, unrolled to eight shift steps.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                             input logic [7:0]  b);
    logic [15:0] c;
    logic        top;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      top = c[15] ^ b[7-k];
      c   = {c[14:0], 1'b0};
      if (top) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

endpackage

>>> hw/rtl/payload_crc16_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// payload_crc16_frame_checker
// Passes frame payload bytes on and checks the trailing CRC-16 of each frame.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                Payload
//  in_*      input      in_valid / in_stall      pcfc_pkg::in_word_t
//  out_*     output     out_valid / out_stall    pcfc_pkg::out_word_t
//  cfg_*     input      cfg_wr_en                cfg_wr_data (emit_verdict)
//
// One word is accepted every cycle while in_stall is low; any result of it
// is registered in the output register, or in the skid register if stalled.
// The CRC update is a single unrolled byte step between the frame state
// registers. A skid register absorbs one result when out_stall is high,
// and in_stall is raised only while that skid register is full.
// rst_n is synchronous; after reset no frame is open and emit_verdict is 1.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module payload_crc16_frame_checker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  pcfc_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output pcfc_pkg::out_word_t  out_data,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_wr_data
);
  import pcfc_pkg::*;

  logic        emit_verdict_r;
  logic [15:0] crc_r, crc_nxt;
  logic [8:0]  idx_r, idx_nxt;
  logic [7:0]  len_r, len_nxt;
  logic        has_crc_r, has_crc_nxt;
  logic [15:0] tail_r, tail_nxt;
  logic [7:0]  rx_low_r, rx_low_nxt;

  logic        out_valid_r;
  out_word_t   out_data_r;
  logic        skid_valid_r;
  out_word_t   skid_data_r;

  logic        accept;
  logic        out_take;
  logic        res_valid;
  out_word_t   res;

  logic [7:0]  len_sat;
  logic [7:0]  n;
  logic        has;
  logic [8:0]  i;
  logic [8:0]  total;
  logic [7:0]  n_m2;
  logic        n_ge2;
  logic [15:0] crc_cur;
  logic [15:0] tail_cur;
  logic [7:0]  rx_low_cur;

  assign in_stall  = skid_valid_r;
  assign accept    = in_valid && !in_stall;
  assign out_take  = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Frame start reloads the frame state before the word itself is handled.
  always_comb begin
    len_sat    = (in_data.payload_length > MAX_PAYLOAD_BYTES) ?
                 MAX_PAYLOAD_BYTES : in_data.payload_length;
    n          = in_data.frame_start ? len_sat : len_r;
    has        = in_data.frame_start ? in_data.crc_present : has_crc_r;
    i          = in_data.frame_start ? 9'd0 : idx_r;
    crc_cur    = in_data.frame_start ? CRC_INIT : crc_r;
    tail_cur   = in_data.frame_start ? 16'd0 : tail_r;
    rx_low_cur = in_data.frame_start ? 8'd0 : rx_low_r;
    total      = {1'b0, n} + (has ? 9'd2 : 9'd0);
    n_ge2      = (n >= 8'd2);
    n_m2       = n - 8'd2;

    len_nxt     = n;
    has_crc_nxt = has;
    idx_nxt     = i;
    crc_nxt     = crc_cur;
    tail_nxt    = tail_cur;
    rx_low_nxt  = rx_low_cur;
    res_valid   = 1'b0;
    res         = '0;

    if (i < total) begin
      idx_nxt = i + 9'd1;
      if (i < {1'b0, n}) begin
        res_valid    = 1'b1;
        res.out_byte = in_data.data_byte;
        if (has && n_ge2) begin
          if (i < {1'b0, n_m2}) begin
            crc_nxt = crc16_byte(crc_cur, in_data.data_byte);
          end else begin
            tail_nxt = {tail_cur[7:0], in_data.data_byte};
          end
          res.end_of_frame = (i == {1'b0, n} - 9'd1) && !emit_verdict_r;
        end else if (!has) begin
          res.end_of_frame = (i == {1'b0, n} - 9'd1);
        end
      end else if (i == {1'b0, n}) begin
        // First CRC byte is only stored.
        rx_low_nxt = in_data.data_byte;
      end else if (!n_ge2) begin
        res_valid          = 1'b1;
        res.is_verdict     = 1'b1;
        res.end_of_frame   = 1'b1;
        res.length_error   = 1'b1;
      end else if (emit_verdict_r) begin
        res_valid          = 1'b1;
        res.is_verdict     = 1'b1;
        res.end_of_frame   = 1'b1;
        res.crc_ok         = ((crc_cur ^ tail_cur) == {in_data.data_byte, rx_low_cur});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_verdict_r <= 1'b1;
      idx_r          <= '0;
      len_r          <= '0;
      has_crc_r      <= 1'b0;
      crc_r          <= CRC_INIT;
      tail_r         <= '0;
      rx_low_r       <= '0;
    end else begin
      if (cfg_wr_en) begin
        emit_verdict_r <= cfg_wr_data;
      end
      if (accept) begin
        idx_r     <= idx_nxt;
        len_r     <= len_nxt;
        has_crc_r <= has_crc_nxt;
        crc_r     <= crc_nxt;
        tail_r    <= tail_nxt;
        rx_low_r  <= rx_low_nxt;
      end
    end
  end

  // Output register with a one-word skid behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (skid_valid_r) begin
        if (out_take) begin
          out_data_r   <= skid_data_r;
          skid_valid_r <= 1'b0;
        end
      end else if (accept && res_valid) begin
        if (!out_valid_r || out_take) begin
          out_data_r  <= res;
          out_valid_r <= 1'b1;
        end else begin
          skid_data_r  <= res;
          skid_valid_r <= 1'b1;
        end
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  `ASSERT_SYNC(a_skid_behind_out, !skid_valid_r || out_valid_r, "skid full with output empty")
  `ASSERT_SYNC(a_verdict_ends, !(out_valid_r && out_data_r.is_verdict) || out_data_r.end_of_frame, "verdict word not marked end of frame")
  `ASSERT_SYNC(a_lerr_verdict, !(out_valid_r && out_data_r.length_error) || (out_data_r.is_verdict && !out_data_r.crc_ok), "length error on a non-verdict or passing word")
  `ASSERT_NEXT(a_skid_drains, skid_valid_r && !out_stall, !skid_valid_r, "skid did not drain on output take")
  `ASSERT_SYNC(a_index_bound, idx_r <= 9'd257, "byte index beyond longest frame")

endmodule
